### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b in the same cycle
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// a implies b in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

### sv/jpdm_pkg.sv
// Package for the jogged PD joint and drive mixer: widths, codes, helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package jpdm_pkg;
  localparam int ARM_JOINTS = 4;
  localparam int JOINTS = ARM_JOINTS + 1;
  localparam int MA_W = 25;
  localparam int MB_W = 21;
  localparam int MP_W = MA_W + MB_W;
  localparam int ACC_W = 66;

  localparam logic [2:0] REG_BASE_P = 3'd0;
  localparam logic [2:0] REG_BASE_D = 3'd1;
  localparam logic [2:0] REG_ARM_P = 3'd2;
  localparam logic [2:0] REG_ARM_D = 3'd3;
  localparam logic [2:0] REG_DEADBAND = 3'd4;
  localparam logic [2:0] REG_JOG_STEP = 3'd5;
  localparam logic [2:0] REG_TPS = 3'd6;
  localparam logic [2:0] REG_DRIVE = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -ACC_W'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

### sv/jog_pd_joint_and_drive_mixer.sv
// Top level of the jogged PD joint controller and differential drive mixer.
// Depends on jpdm_pkg, jpdm_mul and assert_macros.svh.
//
// One input word is one control tick; it yields one output word of five
// torques and two wheel speeds. A small sequencer drives one shared
// 25x21 multiplier: each joint takes seven multiplies (jog step, two
// partial products of the velocity error, two of P and two of D), the
// drive mix two more. The result word is registered once the last multiply
// is done and the output register is free; only then does the sequencer
// go idle for the next tick. in_ready is low while a tick is being worked.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jog_pd_joint_and_drive_mixer import jpdm_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] base_angle,
  input  wire logic signed [31:0] arm_angle_fr,
  input  wire logic signed [31:0] arm_angle_fl,
  input  wire logic signed [31:0] arm_angle_rl,
  input  wire logic signed [31:0] arm_angle_rr,
  input  wire logic signed [15:0] axis_base,
  input  wire logic signed [15:0] axis_front_arms,
  input  wire logic signed [15:0] axis_rear_arms,
  input  wire logic signed [15:0] axis_forward,
  input  wire logic signed [15:0] axis_turn,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      base_torque,
  output logic signed [31:0]      torque_fr,
  output logic signed [31:0]      torque_fl,
  output logic signed [31:0]      torque_rl,
  output logic signed [31:0]      torque_rr,
  output logic signed [31:0]      left_speed,
  output logic signed [31:0]      right_speed
);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [23:0] base_p, base_d, arm_p, arm_d;
  logic [14:0] deadband;
  logic [15:0] jog_step, tps, drive;

  logic [1:0] st;
  logic [2:0] j, s;
  logic ph, first;

  logic signed [31:0] q [JOINTS];
  logic signed [31:0] refa [JOINTS];
  logic signed [31:0] prev [JOINTS];
  logic signed [31:0] trq [JOINTS];
  logic signed [16:0] ax_b, ax_f, ax_r, fwd, trn;
  logic signed [34:0] verr;
  logic signed [38:0] vel;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] lsp, rsp;

  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  logic signed [MP_W-1:0] mp;

  logic [2:0] ji;
  logic signed [16:0] ax_j;
  logic [23:0] pg, dg;
  logic signed [32:0] ang;
  logic signed [17:0] mag;
  logic signed [ACC_W-1:0] prod_x, acc_next, shifted;
  logic signed [17:0] delta_next;

  assign cfg_ready = 1'b1;
  assign in_ready = (st == ST_IDLE);
  assign ji = (j < 3'(JOINTS)) ? j : 3'd0;

  always_comb begin
    case (j)
      3'd0: ax_j = ax_b;
      3'd1, 3'd2: ax_j = ax_f;
      default: ax_j = ax_r;
    endcase
    pg = (j == 3'd0) ? base_p : arm_p;
    dg = (j == 3'd0) ? base_d : arm_d;
    ang = 33'(refa[ji]) - 33'(q[ji]);
    mag = (ax_j < 0) ? -18'(ax_j) : 18'(ax_j);
    prod_x = ACC_W'(mp);
    ma = '0;
    mb = '0;
    if (j == 3'd5) begin
      ma = MA_W'({1'b0, drive});
      mb = (s == 3'd0) ? MB_W'(18'(fwd) + 18'(trn)) : MB_W'(18'(fwd) - 18'(trn));
    end else begin
      case (s)
        3'd0: begin ma = MA_W'({1'b0, jog_step}); mb = MB_W'(ax_j); end
        3'd1: begin ma = MA_W'({1'b0, tps}); mb = MB_W'({1'b0, verr[19:0]}); end
        3'd2: begin ma = MA_W'({1'b0, tps}); mb = MB_W'($signed(verr[34:20])); end
        3'd3: begin ma = MA_W'({1'b0, pg}); mb = MB_W'({1'b0, ang[19:0]}); end
        3'd4: begin ma = MA_W'({1'b0, pg}); mb = MB_W'($signed(ang[32:20])); end
        3'd5: begin ma = MA_W'({1'b0, dg}); mb = MB_W'({1'b0, vel[19:0]}); end
        default: begin ma = MA_W'({1'b0, dg}); mb = MB_W'($signed(vel[38:20])); end
      endcase
    end
    shifted = (s == 3'd2 || s == 3'd4 || s == 3'd6) ? (prod_x <<< 20) : prod_x;
    acc_next = ((s == 3'd1 || s == 3'd3) ? ACC_W'(0) : acc) + shifted;
    delta_next = (mag > 18'(deadband)) ? 18'(prod_x >>> 15) : 18'sd0;
  end

  jpdm_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_p <= 24'd51200;
      base_d <= 24'd12800;
      arm_p <= 24'd12800;
      arm_d <= 24'd2560;
      deadband <= 15'd8192;
      jog_step <= 16'd131;
      tps <= 16'd1000;
      drive <= 16'd2560;
    end else if (cfg_valid) begin
      case (cfg_index)
        8'(REG_BASE_P): base_p <= cfg_data[23:0];
        8'(REG_BASE_D): base_d <= cfg_data[23:0];
        8'(REG_ARM_P): arm_p <= cfg_data[23:0];
        8'(REG_ARM_D): arm_d <= cfg_data[23:0];
        8'(REG_DEADBAND): deadband <= cfg_data[14:0];
        8'(REG_JOG_STEP): jog_step <= cfg_data[15:0];
        8'(REG_TPS): tps <= cfg_data[15:0];
        8'(REG_DRIVE): drive <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      j <= '0;
      s <= '0;
      ph <= 1'b0;
      first <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < JOINTS; i++) begin
        refa[i] <= '0;
        prev[i] <= '0;
      end
    end else begin
      if (out_valid && out_ready && st != ST_DONE) out_valid <= 1'b0;
      case (st)
        ST_IDLE: begin
          if (in_valid) begin
            q[0] <= base_angle;
            q[1] <= arm_angle_fr;
            q[2] <= arm_angle_fl;
            q[3] <= arm_angle_rl;
            q[4] <= arm_angle_rr;
            ax_b <= 17'(axis_base);
            ax_f <= 17'(axis_front_arms);
            ax_r <= -17'(axis_rear_arms);
            fwd <= -17'(axis_forward);
            trn <= 17'(axis_turn);
            if (first) begin
              refa[0] <= base_angle; prev[0] <= base_angle;
              refa[1] <= arm_angle_fr; prev[1] <= arm_angle_fr;
              refa[2] <= arm_angle_fl; prev[2] <= arm_angle_fl;
              refa[3] <= arm_angle_rl; prev[3] <= arm_angle_rl;
              refa[4] <= arm_angle_rr; prev[4] <= arm_angle_rr;
            end
            first <= 1'b0;
            j <= '0;
            s <= '0;
            ph <= 1'b0;
            st <= ST_RUN;
          end
        end
        ST_RUN: begin
          ph <= ~ph;
          if (ph) begin
            acc <= acc_next;
            s <= s + 3'd1;
            if (j == 3'd5) begin
              if (s == 3'd0) lsp <= sat32(prod_x >>> 7);
              else begin
                rsp <= sat32(prod_x >>> 7);
                st <= ST_DONE;
              end
            end else begin
              case (s)
                3'd0: begin
                  refa[ji] <= sat32(ACC_W'(refa[ji]) + ACC_W'(delta_next));
                  verr <= 35'(delta_next) - (35'(q[ji]) - 35'(prev[ji]));
                end
                3'd2: begin
                  if (acc_next > ACC_W'(64'sd274877906943)) vel <= 39'sh3fffffffff;
                  else if (acc_next < -ACC_W'(64'sd274877906943))
                    vel <= -39'sh3fffffffff;
                  else vel <= acc_next[38:0];
                end
                3'd6: begin
                  trq[ji] <= sat32(acc_next >>> 8);
                  prev[ji] <= q[ji];
                  j <= j + 3'd1;
                  s <= '0;
                end
                default: ;
              endcase
            end
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            base_torque <= trq[0];
            torque_fr <= trq[1];
            torque_fl <= trq[2];
            torque_rl <= trq[3];
            torque_rr <= trq[4];
            left_speed <= lsp;
            right_speed <= rsp;
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLY(a_busy_not_ready, clk, rst, st != ST_IDLE, !in_ready)
  `ASSERT_NEXT(a_accept_runs, clk, rst, in_valid && in_ready, st == ST_RUN)
  `ASSERT_NEXT(a_out_held, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_IMPLY(a_run_bounds, clk, rst, st == ST_RUN, j <= 3'd5 && s <= 3'd6)
endmodule
`default_nettype wire

### sv/jpdm_mul.sv
// Shared registered signed multiplier, 25 by 21 bits.
// Depends on jpdm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module jpdm_mul import jpdm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic signed [MA_W-1:0] a,
  input  wire logic signed [MB_W-1:0] b,
  output logic signed [MP_W-1:0]      p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire
